/* hw/rtl/aat_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aat_pkg: shared types and constants of the aging address table
// Entry layout, event and command codes, and the fixed limits of the table.
// ----------------------------------------------------------------------------
package aat_pkg;

  // Default number of table entries (top-level parameter default).
  localparam int unsigned CAPACITY_DEF = 64;

  // Most expiry events that one tick may report.
  localparam int unsigned MAX_RESULTS = 64;

  // Timeout register value after reset, in ticks.
  localparam logic [31:0] TIMEOUT_RESET = 32'd300;

  // Width of the reported entry count.
  localparam int unsigned COUNT_W = 7;

  typedef enum logic [1:0] {
    KIND_ADDED     = 2'd0,
    KIND_REFRESHED = 2'd1,
    KIND_DROPPED   = 2'd2,
    KIND_EXPIRED   = 2'd3
  } event_kind_e;

  typedef enum logic {
    CMD_LEARN = 1'b0,
    CMD_TICK  = 1'b1
  } command_e;

  // One table entry: stamp in the upper half, address in the lower half.
  typedef struct packed {
    logic [31:0] stamp;
    logic [31:0] addr;
  } entry_t;

endpackage

/* hw/rtl/aat_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aat_mem: entry memory of the aging address table
// One write port and one read port; read data registered and held while no
// read is issued.
// ----------------------------------------------------------------------------
module aat_mem import aat_pkg::*; #(
  parameter int unsigned DEPTH = CAPACITY_DEF,
  parameter int unsigned AW    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold the last read word until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/aat_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aat_seq: scan sequencer of the aging address table
// Walks the entry memory for learn and tick transactions, keeps the entry
// count and the time counter, and drives the registered result stage.
// ----------------------------------------------------------------------------
module aat_seq import aat_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  parameter int unsigned AW       = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [31:0]         timeout_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  command_e            in_cmd_i,
  input  logic [31:0]         in_addr_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output event_kind_e         out_kind_o,
  output logic [31:0]         out_addr_o,
  output logic [COUNT_W-1:0]  out_count_o,
  output logic                out_last_o,
  output logic                mem_we_o,
  output logic [AW-1:0]       mem_waddr_o,
  output entry_t              mem_wdata_o,
  output logic                mem_re_o,
  output logic [AW-1:0]       mem_raddr_o,
  input  entry_t              mem_rdata_i
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned NW = $clog2(MAX_RESULTS + 1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_LCHK = 6'b000010,
    ST_LEND = 6'b000100,
    ST_TCHK = 6'b001000,
    ST_TMOV = 6'b010000,
    ST_TFIN = 6'b100000
  } state_e;

  function automatic logic [COUNT_W-1:0] to_count(input logic [CW-1:0] c);
    logic [CW+COUNT_W-1:0] w;
    w = {{COUNT_W{1'b0}}, c};
    return w[COUNT_W-1:0];
  endfunction

  state_e             state_q, state_d;
  logic [31:0]        ip_q, ip_d;
  logic [31:0]        now_q, now_d;
  logic [CW-1:0]      count_q, count_d;
  logic [AW-1:0]      idx_q, idx_d;
  logic [NW-1:0]      nres_q, nres_d;
  logic               pend_valid_q, pend_valid_d;
  logic [31:0]        pend_addr_q, pend_addr_d;
  logic [COUNT_W-1:0] pend_cnt_q, pend_cnt_d;

  logic               out_valid_q, out_valid_d;
  event_kind_e        out_kind_q, out_kind_d;
  logic [31:0]        out_addr_q, out_addr_d;
  logic [COUNT_W-1:0] out_cnt_q, out_cnt_d;
  logic               out_last_q, out_last_d;

  logic               emit;
  event_kind_e        emit_kind;
  logic [31:0]        emit_addr;
  logic [COUNT_W-1:0] emit_cnt;
  logic               emit_last;

  logic [CW:0]        idx_nxt;
  logic [AW-1:0]      idx_inc;
  logic               more;
  logic               full;
  logic [CW-1:0]      cnt_m1;
  logic [CW-1:0]      cnt_p1;
  logic               expired;
  logic               can_emit;

  assign idx_nxt  = {{(CW + 1 - AW){1'b0}}, idx_q} + (CW + 1)'(1);
  assign idx_inc  = idx_nxt[AW-1:0];
  assign more     = idx_nxt < {1'b0, count_q};
  assign full     = count_q == CW'(CAPACITY);
  assign cnt_m1   = count_q - CW'(1);
  assign cnt_p1   = count_q + CW'(1);
  assign expired  = ({1'b0, mem_rdata_i.stamp} + {1'b0, timeout_i}) < {1'b0, now_q};
  assign can_emit = !out_valid_q || out_ready_i;

  always_comb begin
    state_d      = state_q;
    ip_d         = ip_q;
    now_d        = now_q;
    count_d      = count_q;
    idx_d        = idx_q;
    nres_d       = nres_q;
    pend_valid_d = pend_valid_q;
    pend_addr_d  = pend_addr_q;
    pend_cnt_d   = pend_cnt_q;

    emit      = 1'b0;
    emit_kind = KIND_EXPIRED;
    emit_addr = pend_addr_q;
    emit_cnt  = pend_cnt_q;
    emit_last = 1'b0;

    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q;
    mem_wdata_o = '{stamp: now_q, addr: ip_q};
    mem_re_o    = 1'b0;
    mem_raddr_o = idx_inc;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ip_d        = in_addr_i;
          idx_d       = '0;
          nres_d      = '0;
          mem_raddr_o = '0;
          if (in_cmd_i == CMD_TICK) begin
            now_d = now_q + 32'd1;
            if (count_q != '0) begin
              mem_re_o = 1'b1;
              state_d  = ST_TCHK;
            end
          end else if (count_q != '0) begin
            mem_re_o = 1'b1;
            state_d  = ST_LCHK;
          end else begin
            state_d = ST_LEND;
          end
        end
      end

      ST_LCHK: begin
        if (mem_rdata_i.addr == ip_q) begin
          if (can_emit) begin
            mem_we_o  = 1'b1;
            emit      = 1'b1;
            emit_kind = KIND_REFRESHED;
            emit_addr = ip_q;
            emit_cnt  = to_count(count_q);
            emit_last = 1'b1;
            state_d   = ST_IDLE;
          end
        end else if (more) begin
          mem_re_o = 1'b1;
          idx_d    = idx_inc;
        end else begin
          state_d = ST_LEND;
        end
      end

      ST_LEND: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_addr = ip_q;
          emit_last = 1'b1;
          if (full) begin
            emit_kind = KIND_DROPPED;
            emit_cnt  = to_count(count_q);
          end else begin
            mem_we_o    = 1'b1;
            mem_waddr_o = count_q[AW-1:0];
            count_d     = cnt_p1;
            emit_kind   = KIND_ADDED;
            emit_cnt    = to_count(cnt_p1);
          end
          state_d = ST_IDLE;
        end
      end

      ST_TCHK: begin
        if (expired) begin
          // Flush the held removal first; wait while the output is busy.
          if (!pend_valid_q || can_emit) begin
            emit         = pend_valid_q;
            pend_valid_d = 1'b1;
            pend_addr_d  = mem_rdata_i.addr;
            pend_cnt_d   = to_count(cnt_m1);
            count_d      = cnt_m1;
            nres_d       = nres_q + NW'(1);
            if (more) begin
              // Fetch the last entry to move into the freed slot.
              mem_re_o    = 1'b1;
              mem_raddr_o = cnt_m1[AW-1:0];
              state_d     = ST_TMOV;
            end else begin
              state_d = ST_TFIN;
            end
          end
        end else if (more) begin
          mem_re_o = 1'b1;
          idx_d    = idx_inc;
        end else begin
          state_d = ST_TFIN;
        end
      end

      ST_TMOV: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = mem_rdata_i;
        // Read data still holds the moved entry: check it again in place.
        if (nres_q == NW'(MAX_RESULTS)) begin
          state_d = ST_TFIN;
        end else begin
          state_d = ST_TCHK;
        end
      end

      ST_TFIN: begin
        if (pend_valid_q) begin
          if (can_emit) begin
            emit         = 1'b1;
            emit_last    = 1'b1;
            pend_valid_d = 1'b0;
            state_d      = ST_IDLE;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_kind_d  = out_kind_q;
    out_addr_d  = out_addr_q;
    out_cnt_d   = out_cnt_q;
    out_last_d  = out_last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_kind_d  = emit_kind;
      out_addr_d  = emit_addr;
      out_cnt_d   = emit_cnt;
      out_last_d  = emit_last;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      now_q        <= '0;
      count_q      <= '0;
      nres_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      now_q        <= now_d;
      count_q      <= count_d;
      nres_q       <= nres_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ip_q        <= ip_d;
    idx_q       <= idx_d;
    pend_addr_q <= pend_addr_d;
    pend_cnt_q  <= pend_cnt_d;
    out_kind_q  <= out_kind_d;
    out_addr_q  <= out_addr_d;
    out_cnt_q   <= out_cnt_d;
    out_last_q  <= out_last_d;
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_addr_o  = out_addr_q;
  assign out_count_o = out_cnt_q;
  assign out_last_o  = out_last_q;

endmodule

/* hw/rtl/aging_address_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aging_address_table: learning table of IPv4 addresses with aging
// Learns addresses with a time stamp, refreshes known ones, and on every
// tick removes expired entries by moving the last entry into the hole.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Transaction content
//  --------  ---------  -----------------------------------------------------
//  cfg       in         timeout_ticks (32 bit), written when cfg_we_i is high
//  s_axis    in         tuser = command, tdata = ip_addr
//  m_axis    out        tuser = event_kind, tdata = event_addr, entry_count,
//                       tlast = last result of the input transaction
//
//  The single read port of the entry memory paces every scan: one entry is read
//  per cycle while the scan does not wait on the master side, and a tick also
//  moves the last entry into each freed slot.
//  Reset clears the count, the time counter and the valid flags and loads the
//  timeout register with its reset value; the entry memory needs no clearing
//  pass since only entries below the count are read. The input is taken only
//  between scans; a scan waits while the registered result is held by a
//  stalled master side.
module aging_address_table import aat_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,      // timeout_ticks

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,     // [31:0] ip_addr
  input  logic [0:0]  s_axis_tuser,     // [0] command

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,     // [31:0] event_addr, [38:32] entry_count, [39] zero
  output logic [1:0]  m_axis_tuser,     // [1:0] event_kind
  output logic        m_axis_tlast
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [31:0]        timeout_q;

  event_kind_e        out_kind;
  logic [31:0]        out_addr;
  logic [COUNT_W-1:0] out_count;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  entry_t             mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  entry_t             mem_rdata;

  // Hold the timeout register; the user must write it only while the table is idle, the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  aat_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  aat_seq #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .timeout_i   (timeout_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (command_e'(s_axis_tuser[0])),
    .in_addr_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (out_kind),
    .out_addr_o  (out_addr),
    .out_count_o (out_count),
    .out_last_o  (m_axis_tlast),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // Pack the result fields, lowest field first, padded to whole bytes.
  assign m_axis_tdata = {1'b0, out_count, out_addr};
  assign m_axis_tuser = out_kind;

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the aging address table
// Learn and tick transactions go in on the slave side, and the bench keeps a
// shadow copy of the table to predict every added, refreshed, dropped and
// expired event. Each event on the master side is checked against the oldest
// prediction. Both sides stall in random bursts but in the final part; the
// timeout register changes between phases: zero, all ones, small, random.
// ----------------------------------------------------------------------------
module tb import aat_pkg::*;;

  localparam int unsigned POOL_SIZE  = 20;
  localparam int unsigned SETTLE_CYC = 150;   // covers the longest tick scan
  localparam int unsigned STALL_MAX  = 4000;  // cycles without any transaction

  // One predicted or observed output event.
  typedef struct packed {
    event_kind_e kind;
    logic [31:0] addr;
    logic [6:0]  count;
    logic        last;
  } table_event_t;

  class address_table_scoreboard;
    logic [31:0]  shadow_addr[CAPACITY_DEF];
    logic [31:0]  shadow_stamp[CAPACITY_DEF];
    int unsigned  shadow_count;
    logic [31:0]  shadow_now;
    logic [31:0]  shadow_timeout;
    table_event_t expected_events[$];
    int unsigned  mismatches;

    function new();
      shadow_count   = 0;
      shadow_now     = '0;
      shadow_timeout = TIMEOUT_RESET;
      mismatches     = 0;
    endfunction

    function void set_timeout(logic [31:0] value);
      shadow_timeout = value;
    endfunction

    function int unsigned outstanding();
      return expected_events.size();
    endfunction

    // Update the shadow table for one accepted command and queue its events.
    function void note_command(command_e cmd, logic [31:0] ip);
      table_event_t ev;
      table_event_t burst[$];
      int unsigned  i;
      int unsigned  k;
      logic [31:0]  gone;
      bit           found;
      if (cmd == CMD_LEARN) begin
        found = 0;
        for (i = 0; i < shadow_count; i++) begin
          if (!found && shadow_addr[i] == ip) begin
            shadow_stamp[i] = shadow_now;
            found = 1;
          end
        end
        if (found) begin
          ev.kind = KIND_REFRESHED;
        end else if (shadow_count >= CAPACITY_DEF) begin
          ev.kind = KIND_DROPPED;
        end else begin
          shadow_addr[shadow_count]  = ip;
          shadow_stamp[shadow_count] = shadow_now;
          shadow_count++;
          ev.kind = KIND_ADDED;
        end
        ev.addr  = ip;
        ev.count = 7'(shadow_count);
        ev.last  = 1'b1;
        expected_events.push_back(ev);
      end else begin
        shadow_now = shadow_now + 32'd1;
        i = 0;
        // Swap the last entry into a freed slot and test that slot again.
        while (i < shadow_count && burst.size() < MAX_RESULTS) begin
          if ({1'b0, shadow_stamp[i]} + {1'b0, shadow_timeout} < {1'b0, shadow_now}) begin
            gone = shadow_addr[i];
            shadow_count--;
            shadow_addr[i]  = shadow_addr[shadow_count];
            shadow_stamp[i] = shadow_stamp[shadow_count];
            ev.kind  = KIND_EXPIRED;
            ev.addr  = gone;
            ev.count = 7'(shadow_count);
            ev.last  = 1'b0;
            burst.push_back(ev);
          end else begin
            i++;
          end
        end
        for (k = 0; k < burst.size(); k++) begin
          ev = burst[k];
          ev.last = (k == burst.size() - 1);
          expected_events.push_back(ev);
        end
      end
    endfunction

    function void check_event(table_event_t got);
      table_event_t want;
      if (expected_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected event: kind=%0d addr=%h count=%0d last=%0b",
                   got.kind, got.addr, got.count, got.last);
        return;
      end
      want = expected_events.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("event mismatch: expected kind=%0d addr=%h count=%0d last=%0b,",
                   want.kind, want.addr, want.count, want.last,
                   " got kind=%0d addr=%h count=%0d last=%0b",
                   got.kind, got.addr, got.count, got.last);
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [31:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic [0:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  address_table_scoreboard sb;
  logic [31:0] addr_pool[POOL_SIZE];
  bit          src_idle_en  = 1'b1;
  bit          sink_idle_en = 1'b1;

  aging_address_table i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Drive one command; return right after the edge that takes it.
  // Keep tvalid high between back-to-back transactions.
  task automatic send_item(input command_e cmd, input logic [31:0] ip);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ip;
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_command(cmd, ip);
  endtask

  task automatic stop_input();
    s_axis_tvalid <= 1'b0;
  endtask

  // Drain all events, let a silent tick scan finish, then write the timeout.
  task automatic write_timeout(input logic [31:0] value);
    stop_input();
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_timeout(value);
  endtask

  // Mostly known addresses so that refreshes are common.
  function automatic logic [31:0] pick_addr();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (sel < 8 && sb.shadow_count != 0)
      return sb.shadow_addr[$urandom_range(0, sb.shadow_count - 1)];
    return $urandom();
  endfunction

  task automatic run_mix(input int unsigned n_items, input int unsigned tick_pct);
    int unsigned k;
    for (k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 99) < tick_pct) send_item(CMD_TICK, $urandom());
      else send_item(CMD_LEARN, pick_addr());
    end
  endtask

  // Master side: hold tready low in random bursts.
  initial begin
    forever begin
      if (sink_idle_en && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
    end
  end

  // Check every event transaction against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_event('{kind:  event_kind_e'(m_axis_tuser),
                       addr:  m_axis_tdata[31:0],
                       count: m_axis_tdata[38:32],
                       last:  m_axis_tlast});
  end

  // Watchdog: end the run when nothing moves for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_MAX) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    int unsigned k;
    sb = new();
    for (k = 0; k < POOL_SIZE; k++) addr_pool[k] = $urandom();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, refresh, swap-in entry that is also expired,
    // tick on an empty table.
    write_timeout(32'd2);
    send_item(CMD_LEARN, 32'h0000_0000);
    send_item(CMD_LEARN, 32'hFFFF_FFFF);
    send_item(CMD_LEARN, 32'h0000_0000);
    send_item(CMD_LEARN, 32'hA5A5_A5A5);
    send_item(CMD_TICK,  32'h0000_0000);
    send_item(CMD_LEARN, 32'h5A5A_5A5A);
    send_item(CMD_TICK,  32'hFFFF_FFFF);
    send_item(CMD_TICK,  32'h1234_5678);
    send_item(CMD_TICK,  32'h0000_0000);
    send_item(CMD_TICK,  32'hFFFF_FFFF);
    send_item(CMD_LEARN, 32'h8000_0001);
    send_item(CMD_TICK,  32'h0000_0000);

    // Zero timeout: an entry expires on the first tick after its refresh.
    write_timeout(32'd0);
    run_mix(40, 40);

    write_timeout(32'd5);
    run_mix(40, 25);

    // Largest timeout: nothing expires. Fill the table, then drop new
    // addresses and refresh stored ones while it is full.
    write_timeout(32'hFFFF_FFFF);
    while (sb.shadow_count < CAPACITY_DEF) send_item(CMD_LEARN, $urandom());
    run_mix(30, 20);

    // Back to zero: one tick removes the whole table.
    write_timeout(32'd0);
    send_item(CMD_TICK, $urandom());
    run_mix(40, 30);

    write_timeout(32'($urandom_range(1, 12)));
    run_mix(60, 30);

    // Final part with no stalls on either side.
    write_timeout($urandom());
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    run_mix(40, 30);

    stop_input();
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* aging_address_table.f */
hw/rtl/aat_pkg.sv
hw/rtl/aat_mem.sv
hw/rtl/aat_seq.sv
hw/rtl/aging_address_table.sv
dv/tb.sv
